// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define FCPM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that stays live through reset
`define FCPM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/fcpm_pkg.sv
// package: types, constants and tables of the false color palette mapper
`timescale 1ns / 1ps
package fcpm_pkg;

  localparam int MAX_PALETTE = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int RECIP_SHIFT = 24;

  // configuration register indexes
  localparam logic [3:0] REG_SOFT_MODE = 4'd0;
  localparam logic [3:0] REG_PAL_SIZE  = 4'd1;
  localparam logic [3:0] REG_PAL_A     = 4'd2;
  localparam logic [3:0] REG_PAL_F     = 4'd7;

  typedef enum logic {
    K_WORD  = 1'b0,
    K_BLEND = 1'b1
  } kind_t;

  typedef struct packed {
    logic                         soft_mode;
    logic [2:0]                   pal_size;
    logic [MAX_PALETTE-1:0][31:0] pal;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [23:0] col_lo;
    logic [23:0] col_hi;
    logic [7:0]  wt_hi;
    logic [7:0]  wt_lo;
    logic [7:0]  span;
    logic        frame_end;
  } q_entry_t;

  function automatic logic [31:0] pal_pick(input cfg_t c, input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0:    r = c.pal[0];
      3'd1:    r = c.pal[1];
      3'd2:    r = c.pal[2];
      3'd3:    r = c.pal[3];
      3'd4:    r = c.pal[4];
      3'd5:    r = c.pal[5];
      default: r = c.pal[0];
    endcase
    return r;
  endfunction

  // floor(x / 255) for x below 1536
  function automatic logic [2:0] div255(input logic [10:0] x);
    logic [2:0] q;
    q = 3'd0;
    if (x >= 11'd255)  q = 3'd1;
    if (x >= 11'd510)  q = 3'd2;
    if (x >= 11'd765)  q = 3'd3;
    if (x >= 11'd1020) q = 3'd4;
    if (x >= 11'd1275) q = 3'd5;
    if (x >= 11'd1530) q = 3'd6;
    return q;
  endfunction

  // floor(255 * k / m) for segment count m and boundary k
  function automatic logic [7:0] seg_bound(input logic [2:0] m, input logic [2:0] k);
    logic [7:0] r;
    case ({m, k})
      {3'd1, 3'd1}: r = 8'd255;
      {3'd2, 3'd1}: r = 8'd127;
      {3'd2, 3'd2}: r = 8'd255;
      {3'd3, 3'd1}: r = 8'd85;
      {3'd3, 3'd2}: r = 8'd170;
      {3'd3, 3'd3}: r = 8'd255;
      {3'd4, 3'd1}: r = 8'd63;
      {3'd4, 3'd2}: r = 8'd127;
      {3'd4, 3'd3}: r = 8'd191;
      {3'd4, 3'd4}: r = 8'd255;
      {3'd5, 3'd1}: r = 8'd51;
      {3'd5, 3'd2}: r = 8'd102;
      {3'd5, 3'd3}: r = 8'd153;
      {3'd5, 3'd4}: r = 8'd204;
      {3'd5, 3'd5}: r = 8'd255;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

  // floor(2^24 / d) for every segment width that occurs
  function automatic logic [18:0] recip(input logic [7:0] d);
    logic [18:0] r;
    case (d)
      8'd255:  r = 19'd65793;
      8'd128:  r = 19'd131072;
      8'd127:  r = 19'd132104;
      8'd85:   r = 19'd197379;
      8'd64:   r = 19'd262144;
      8'd63:   r = 19'd266305;
      8'd51:   r = 19'd328965;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/false_color_palette_mapper_core.sv
// top level of the false color palette mapper
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | sink      | in_tvalid/in_tready   | in_tdata pixel, in_tlast frame end
// out     | source    | out_tvalid/out_tready | out_tdata pixel, out_tlast frame end
// cfg     | sink      | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// one item per clock while the output is not stalled; the accept loads the front register,
// then the item moves through queue, numerator, reciprocal product and output register
// in that order
// the front and back stall on their own; a four-entry queue sits between them
// reset is synchronous, active low; it empties the pipe and loads the default palette
// cfg_ready is always high; registers must be written only while the block is idle
module false_color_palette_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_in
  input  logic        in_tlast,   // frame_end_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pixel_out
  output logic        out_tlast,  // frame_end_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fcpm_pkg::*;

  cfg_t     cfg_r;
  q_entry_t q_wdata, q_rdata;
  logic     q_wr, q_full, q_rd, q_valid;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_mode <= 1'b0;
      cfg_r.pal_size  <= 3'd4;
      cfg_r.pal[0]    <= 32'hFF000000;
      cfg_r.pal[1]    <= 32'hFFFF0000;
      cfg_r.pal[2]    <= 32'hFFFFFFFF;
      cfg_r.pal[3]    <= 32'hFFFFFFFF;
      cfg_r.pal[4]    <= 32'hFF000000;
      cfg_r.pal[5]    <= 32'hFF000000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        REG_SOFT_MODE:          cfg_r.soft_mode <= cfg_data[0];
        REG_PAL_SIZE:           cfg_r.pal_size  <= cfg_data[2:0];
        [REG_PAL_A:REG_PAL_F]:  cfg_r.pal[3'(cfg_index - REG_PAL_A)] <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: gray level and palette selection
  fcpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel     (in_tdata),
    .frame_end (in_tlast),
    .q_wr      (q_wr),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // decoupling queue
  fcpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_data   (q_wdata),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_rdata),
    .not_empty (q_valid)
  );

  // back: blend arithmetic and output register
  fcpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pixel     (out_tdata),
    .frame_end (out_tlast)
  );
endmodule

// File: src/fcpm_queue.sv
// short fifo between the front and back parts
`timescale 1ns / 1ps
module fcpm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  fcpm_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output fcpm_pkg::q_entry_t rd_data,
  output logic              not_empty
);
  import fcpm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;

  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + PW'(rd_en);
    count_nxt  = count_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end
endmodule

// File: src/fcpm_front.sv
// front part: gray level, band or segment choice, palette lookup
`timescale 1ns / 1ps
module fcpm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  fcpm_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        pixel,
  input  logic               frame_end,
  output logic               q_wr,
  output fcpm_pkg::q_entry_t q_data,
  input  logic               q_full
);
  import fcpm_pkg::*;

  logic        vld_r, vld_nxt;
  logic [31:0] px_r;
  logic [7:0]  y_r;
  logic        fe_r;
  logic [12:0] gray_sum;
  logic        take;

  logic [2:0]  n, m, t, low, low_lim;
  logic [7:0]  lo_b, hi_b;
  logic [10:0] ny, my;
  logic [31:0] pw_lo, pw_hi;

  // weighted gray sum, divided by 32
  assign gray_sum = 13'(11 * pixel[23:16]) + {pixel[15:8], 4'b0} + 13'(5 * pixel[7:0]);

  assign q_wr     = vld_r && !q_full;
  assign in_ready = !vld_r || !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = take ? 1'b1 : (q_wr ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r <= pixel;
      y_r  <= gray_sum[12:5];
      fe_r <= frame_end;
    end
  end

  // classification of the held item
  always_comb begin
    n       = (cfg.pal_size > 3'(MAX_PALETTE)) ? 3'(MAX_PALETTE) : cfg.pal_size;
    m       = n - 3'd1;
    ny      = {8'd0, n} * {3'd0, y_r};
    t       = div255(ny);
    if (t > m) t = m;
    my      = {8'd0, m} * {3'd0, y_r};
    low     = div255(my);
    low_lim = m - 3'd1;
    if (low > low_lim) low = low_lim;
    lo_b    = seg_bound(m, low);
    hi_b    = seg_bound(m, low + 3'd1);
    pw_lo   = pal_pick(cfg, low);
    pw_hi   = pal_pick(cfg, low + 3'd1);

    q_data.kind      = (cfg.soft_mode && n >= 3'd2) ? K_BLEND : K_WORD;
    q_data.word      = (n == 3'd0) ? px_r : pal_pick(cfg, t);
    q_data.col_lo    = pw_lo[23:0];
    q_data.col_hi    = pw_hi[23:0];
    q_data.wt_hi     = y_r - lo_b;
    q_data.wt_lo     = hi_b - y_r;
    q_data.span      = hi_b - lo_b;
    q_data.frame_end = fe_r;
  end
endmodule

// File: src/fcpm_back.sv
// back part: linear blend with reciprocal divide, output register
`timescale 1ns / 1ps
module fcpm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fcpm_pkg::q_entry_t q_data,
  output logic               q_rd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        pixel,
  output logic               frame_end
);
  import fcpm_pkg::*;

  logic              adv;
  logic              v1_r, v2_r, vo_r;
  kind_t             k1_r, k2_r;
  logic [31:0]       w1_r, w2_r, po_r;
  logic              f1_r, f2_r, fo_r;
  logic [7:0]        d1_r, d2_r;
  logic [2:0][15:0]  num1_r, num2_r;
  logic [2:0][34:0]  prod2_r;
  logic [2:0][7:0]   chan_o;

  assign adv       = !vo_r || out_ready;
  assign q_rd      = adv && q_valid;
  assign out_valid = vo_r;
  assign pixel     = po_r;
  assign frame_end = fo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
  end

  // correction of the reciprocal quotient, one step at most
  always_comb begin
    logic [7:0]  q0;
    logic [15:0] qd;
    for (int c = 0; c < 3; c++) begin
      q0        = prod2_r[c][RECIP_SHIFT+7:RECIP_SHIFT];
      qd        = {8'd0, q0} * {8'd0, d2_r};
      chan_o[c] = ((num2_r[c] - qd) >= {8'd0, d2_r}) ? q0 + 8'd1 : q0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // blend numerators per channel
      for (int c = 0; c < 3; c++) begin
        num1_r[c] <= {8'd0, q_data.col_lo[c*8 +: 8]} * {8'd0, q_data.wt_lo}
                   + {8'd0, q_data.col_hi[c*8 +: 8]} * {8'd0, q_data.wt_hi};
      end
      k1_r <= q_data.kind;
      w1_r <= q_data.word;
      d1_r <= q_data.span;
      f1_r <= q_data.frame_end;
      // multiply by reciprocal of span
      for (int c = 0; c < 3; c++) begin
        prod2_r[c] <= {19'd0, num1_r[c]} * {16'd0, recip(d1_r)};
      end
      num2_r <= num1_r;
      k2_r   <= k1_r;
      w2_r   <= w1_r;
      d2_r   <= d1_r;
      f2_r   <= f1_r;
      po_r   <= (k2_r == K_BLEND) ? {8'hFF, chan_o[2], chan_o[1], chan_o[0]} : w2_r;
      fo_r   <= f2_r;
    end
  end
endmodule

// File: src/fcpm_checker.sv
// port checker for the false color palette mapper, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_ready
);
  `FCPM_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")
  `FCPM_ASSERT_CLK(a_vld_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled valid dropped")
  `FCPM_ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> $stable(out_tdata), "data changed")
  `FCPM_ASSERT_CLK(a_last_hold, out_tvalid && !out_tready |=> $stable(out_tlast), "last changed")
  `FCPM_ASSERT_CLK(a_cfg_ready, cfg_ready, "configuration port not ready")
endmodule

bind false_color_palette_mapper_core fcpm_checker u_fcpm_checker (.*);

// File: verif/testbench.sv
// testbench for the false color palette mapper: directed table, then randomized phases
`timescale 1ns / 1ps
module testbench;
  import fcpm_pkg::*;

  localparam logic [3:0] REG_UNUSED = 4'd8;  // index past the register file
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_WAIT = 12;    // idle margin after the last expected item has arrived

  typedef enum logic [1:0] {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  index;     // register index for a write row
    logic [31:0] data;      // pixel or register value
    logic        frame_end;
    logic        typed;     // expectation written out in the row
    logic [31:0] pixel_exp;
  } stim_row_t;

  typedef struct {
    logic [31:0] pixel;
    logic        frame_end;
  } mapped_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow copy of the register file
  logic        soft_sh;
  logic [2:0]  size_sh;
  logic [31:0] pal_sh [MAX_PALETTE];

  mapped_px_t  pending_px[$];
  int          errors = 0;
  int          matched = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          soft_px = 0;
  int          pass_px = 0;

  false_color_palette_mapper_core DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still due", cycles, pending_px.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: compare each accepted item against the oldest expectation, draw a random out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, '0);
      end else begin
        if (out_tdata !== pending_px[0].pixel)
          report_mismatch("pixel", out_tdata, pending_px[0].pixel);
        if (out_tlast !== pending_px[0].frame_end)
          report_mismatch("frame end", out_tlast, pending_px[0].frame_end);
        void'(pending_px.pop_front());
        matched++;
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] blend_chan(input int a, input int b, input int y,
                                            input int l, input int h);
    int d, num, v;
    d = h - l;
    num = (y - l) * (b - a) + a * d;
    if (num < 0) num = 0;
    v = num / d;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // gray level through the palette as currently programmed
  function automatic logic [31:0] map_pixel(input logic [31:0] px);
    int n, y, lo, l, h, t;
    logic [31:0] cl, chi;
    n = (size_sh > MAX_PALETTE) ? MAX_PALETTE : size_sh;
    y = (11 * int'(px[23:16]) + 16 * int'(px[15:8]) + 5 * int'(px[7:0])) / 32;
    if (n == 0) return px;
    if (soft_sh && n >= 2) begin
      lo = y * (n - 1) / 255;
      if (lo > n - 2) lo = n - 2;
      l = 255 * lo / (n - 1);
      h = 255 * (lo + 1) / (n - 1);
      cl = pal_sh[lo];
      chi = pal_sh[lo + 1];
      return {8'hFF,
              blend_chan(cl[23:16], chi[23:16], y, l, h),
              blend_chan(cl[15:8], chi[15:8], y, l, h),
              blend_chan(cl[7:0], chi[7:0], y, l, h)};
    end
    t = n * y / 255;
    if (t > n - 1) t = n - 1;
    return pal_sh[t];
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SOFT_MODE) soft_sh = val[0];
    else if (idx == REG_PAL_SIZE) size_sh = val[2:0];
    else if (idx >= REG_PAL_A && idx <= REG_PAL_F) pal_sh[idx - REG_PAL_A] = val;
  endtask

  task automatic send_pixel(input logic [31:0] px, input logic fe,
                            input logic typed, input logic [31:0] want);
    mapped_px_t e;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tlast  <= fe;
    do @(posedge clk); while (!in_tready);
    e.pixel = typed ? want : map_pixel(px);
    e.frame_end = fe;
    if (size_sh == 0) pass_px++;
    else if (soft_sh && size_sh >= 2) soft_px++;
    pending_px.push_back(e);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [7:0] g;
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: begin  // random gray level, can land on any segment boundary
        g = 8'($urandom_range(255));
        return {8'($urandom_range(255)), g, g, g};
      end
      default: return $urandom;
    endcase
  endfunction

  stim_row_t dir_rows[] = '{
    // reset palette: black, red, white, white in hard mode
    '{ROW_PIX, 4'd0, 32'h0000_0000, 1'b0, 1'b1, 32'hFF00_0000},
    '{ROW_PIX, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_PIX, 4'd0, 32'h0080_8080, 1'b0, 1'b0, 32'h0},
    // empty palette passes pixels through
    '{ROW_CFG, REG_PAL_SIZE, 32'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
    '{ROW_PIX, 4'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    // single color in soft mode falls back to entry 0
    '{ROW_CFG, REG_SOFT_MODE, 32'd1, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_SIZE, 32'd1, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h80FF_FFFF, 1'b0, 1'b1, 32'hFF00_0000},
    // two color blend over the whole range
    '{ROW_CFG, REG_PAL_SIZE, 32'd2, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_A, 32'h00FF_00FF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_A + 4'd1, 32'h3300_FF00, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h0070_8090, 1'b0, 1'b0, 32'h0},
    // oversized size saturates to six entries
    '{ROW_CFG, REG_PAL_SIZE, 32'd7, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_A + 4'd2, 32'h0012_3456, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_A + 4'd3, 32'hAB00_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_A + 4'd4, 32'h7788_9900, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_PAL_F, 32'hFFFF_FF00, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h0040_4040, 1'b0, 1'b0, 32'h0},
    // write to an unknown index leaves everything alone
    '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_SOFT_MODE, 32'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_PIX, 4'd0, 32'h00C0_C0C0, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    int idle_tab [4] = '{0, 45, 0, 25};
    int stall_tab[4] = '{0, 0, 45, 25};
    int sizes;
    soft_sh = 1'b0;
    size_sh = 3'd4;
    pal_sh = '{32'hFF00_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFF00_0000, 32'hFF00_0000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].index, dir_rows[i].data);
      else send_pixel(dir_rows[i].data, dir_rows[i].frame_end,
                      dir_rows[i].typed, dir_rows[i].pixel_exp);
    end

    // four pacing phases, each with four fresh palettes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int blk = 0; blk < 4; blk++) begin
        sizes = (blk == 0) ? ((ph % 2) ? 7 : 0) : (blk == 1) ? 6 : $urandom_range(7);
        write_reg(REG_SOFT_MODE, $urandom);
        write_reg(REG_PAL_SIZE, {29'($urandom_range(32'h1FFF_FFFF)), sizes[2:0]});
        for (int k = 0; k < MAX_PALETTE; k++)
          write_reg(REG_PAL_A + k[3:0], $urandom);
        for (int k = 0; k < 100; k++) begin
          // hold off once until the pipe has fully drained
          if (ph == 1 && blk == 2 && k == 50) begin
            in_tvalid <= 1'b0;
            while (pending_px.size() != 0) @(posedge clk);
          end
          send_pixel(rand_pixel(), ($urandom_range(15) == 0), 1'b0, '0);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d pixels over hard, soft and pass-through palettes", matched);
    $display("%0d blended, %0d passed through, under four pacing mixes", soft_px, pass_px);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
